### design/ecd_pkg.sv
// Shared types, widths and register codes for the elevator call dispatcher.
package ecd_pkg;

  // Fixed field widths of the ports
  localparam int FLOOR_W    = 6;
  localparam int NF_W       = 7;
  localparam int NC_W       = 4;
  localparam int CAR_ID_W   = 4;
  localparam int OUT_CNT_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Defaults for the top-level parameters
  localparam int MAX_CARS_DEF   = 8;
  localparam int COUNT_BITS_DEF = 32;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_NUM_FLOORS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_CARS   = 2'd1;
  localparam logic [NF_W-1:0]      NUM_FLOORS_RST = 7'd16;
  localparam logic [NC_W-1:0]      NUM_CARS_RST   = 4'd8;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // latch the incoming call item
    logic rd_en;     // read one car entry
    logic rd_busy;   // read belongs to the busiest pass (else selection pass)
    logic upd;       // write back the chosen car
    logic out_load;  // move the result into the output register
  } ecd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic            call_ok;   // call on the input port is serviceable
    logic            out_free;  // output register can take a result
    logic [NC_W-1:0] num_cars;  // raw car count register
  } ecd_sts_t;

endpackage

### design/elevator_call_dispatch_unit.sv
// Top level of the elevator group call dispatcher.
// Usage:
//   Input channel in_*: one call item per handshake (pickup and destination
//   floor). Output channel out_*: one result item per call, held in an output
//   register until out_ready. Configuration channel cfg_*: index 0 writes
//   num_floors, index 1 writes num_cars; always ready. The user must write it
//   only while idle; the block itself does not enforce this.
// Sequencing, with N the clamped number of cars in use: a dispatched call
//   walks the car store once per entry for the nearest-car selection and once
//   more for the busiest-car search; a rejected call only makes the search for
//   the busiest car. The car store has one read port, so each pass reads the N
//   entries one after another. The result is registered after the last read.
// One call at a time: in_ready is high only while the controller is idle.
// A finished result sits in the output register while the next call is
// taken; if the receiver stalls the following result waits inside the block
// and no further call is accepted.
// Reset: all cars at floor 0 with zero travelled, num_floors 16, num_cars 8,
// no result pending. There is no clearing pass; the car store has per-entry
// valid bits.
module elevator_call_dispatch_unit #(
  parameter int MAX_CARS   = ecd_pkg::MAX_CARS_DEF,
  parameter int COUNT_BITS = ecd_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ecd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ecd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ecd_pkg::FLOOR_W-1:0]    in_pickup_floor,
  input  logic [ecd_pkg::FLOOR_W-1:0]    in_dest_floor,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_accepted,
  output logic [ecd_pkg::CAR_ID_W-1:0]   out_chosen_car,
  output logic [ecd_pkg::FLOOR_W-1:0]    out_pickup_distance,
  output logic [ecd_pkg::CAR_ID_W-1:0]   out_busiest_car,
  output logic [ecd_pkg::OUT_CNT_W-1:0]  out_busiest_count
);
  import ecd_pkg::*;

  localparam int CAR_IDX_W = $clog2(MAX_CARS);

  ecd_cmd_t             cmd;
  ecd_sts_t             sts;
  logic [CAR_IDX_W-1:0] rd_addr;

  // Registers are plain flops, always writable
  assign cfg_ready = 1'b1;

  // Sequencer
  ecd_ctrl #(
    .MAX_CARS  (MAX_CARS),
    .CAR_IDX_W (CAR_IDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  // Car store and arithmetic
  ecd_datapath #(
    .MAX_CARS   (MAX_CARS),
    .COUNT_BITS (COUNT_BITS),
    .CAR_IDX_W  (CAR_IDX_W)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_pickup_floor     (in_pickup_floor),
    .in_dest_floor       (in_dest_floor),
    .cmd                 (cmd),
    .rd_addr             (rd_addr),
    .sts                 (sts),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .out_accepted        (out_accepted),
    .out_chosen_car      (out_chosen_car),
    .out_pickup_distance (out_pickup_distance),
    .out_busiest_car     (out_busiest_car),
    .out_busiest_count   (out_busiest_count)
  );

endmodule

### design/ecd_ctrl.sv
// Controller state machine: sequences the selection, update and busiest passes.
module ecd_ctrl #(
  parameter int MAX_CARS  = ecd_pkg::MAX_CARS_DEF,
  parameter int CAR_IDX_W = $clog2(MAX_CARS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ecd_pkg::ecd_sts_t    sts,
  output ecd_pkg::ecd_cmd_t    cmd,
  output logic [CAR_IDX_W-1:0] rd_addr
);
  import ecd_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SEL     = 3'd1;
  localparam logic [2:0] S_SEL_DRN = 3'd2;
  localparam logic [2:0] S_UPD     = 3'd3;
  localparam logic [2:0] S_BSY     = 3'd4;
  localparam logic [2:0] S_BSY_DRN = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic [CAR_IDX_W-1:0] idx_r, idx_nxt;
  logic [CAR_IDX_W-1:0] last_r, last_nxt;
  logic [7:0]           ncl;
  logic [7:0]           ncl_m1;

  // Clamp the car count to 2..MAX_CARS
  always_comb begin
    priority if (sts.num_cars < NC_W'(2)) begin
      ncl = 8'd2;
    end else if (8'(sts.num_cars) > 8'(MAX_CARS)) begin
      ncl = 8'(MAX_CARS);
    end else begin
      ncl = 8'(sts.num_cars);
    end
  end
  assign ncl_m1 = ncl - 8'd1;

  assign in_ready = (state_r == S_IDLE);
  assign rd_addr  = idx_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    last_nxt  = last_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          idx_nxt   = '0;
          last_nxt  = ncl_m1[CAR_IDX_W-1:0];
          state_nxt = sts.call_ok ? S_SEL : S_BSY;
        end
      end
      S_SEL: begin
        cmd.rd_en = 1'b1;
        if (idx_r == last_r) begin
          state_nxt = S_SEL_DRN;
        end else begin
          idx_nxt = idx_r + CAR_IDX_W'(1);
        end
      end
      S_SEL_DRN: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        idx_nxt   = '0;
        state_nxt = S_BSY;
      end
      S_BSY: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_busy = 1'b1;
        if (idx_r == last_r) begin
          state_nxt = S_BSY_DRN;
        end else begin
          idx_nxt = idx_r + CAR_IDX_W'(1);
        end
      end
      S_BSY_DRN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      last_r  <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule

### design/ecd_datapath.sv
// Datapath: configuration, car state store, comparators and output register.
module ecd_datapath #(
  parameter int MAX_CARS   = ecd_pkg::MAX_CARS_DEF,
  parameter int COUNT_BITS = ecd_pkg::COUNT_BITS_DEF,
  parameter int CAR_IDX_W  = $clog2(MAX_CARS)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic [ecd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ecd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [ecd_pkg::FLOOR_W-1:0]       in_pickup_floor,
  input  logic [ecd_pkg::FLOOR_W-1:0]       in_dest_floor,
  input  ecd_pkg::ecd_cmd_t                 cmd,
  input  logic [CAR_IDX_W-1:0]              rd_addr,
  output ecd_pkg::ecd_sts_t                 sts,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic                              out_accepted,
  output logic [ecd_pkg::CAR_ID_W-1:0]      out_chosen_car,
  output logic [ecd_pkg::FLOOR_W-1:0]       out_pickup_distance,
  output logic [ecd_pkg::CAR_ID_W-1:0]      out_busiest_car,
  output logic [ecd_pkg::OUT_CNT_W-1:0]     out_busiest_count
);
  import ecd_pkg::*;

  // Configuration registers
  logic [NF_W-1:0] nf_r;
  logic [NC_W-1:0] nc_r;

  // Latched call item
  logic [FLOOR_W-1:0] pick_r, dest_r, ride_r;
  logic               ok_r;

  // Car store: one entry per car, valid bit means written since reset
  logic [FLOOR_W-1:0]    mem_floor [MAX_CARS];
  logic [COUNT_BITS-1:0] mem_trav  [MAX_CARS];
  logic [MAX_CARS-1:0]   vld_r;

  // Registered read port
  logic [FLOOR_W-1:0]    rd_floor_r;
  logic [COUNT_BITS-1:0] rd_trav_r;
  logic                  rd_vld_r;
  logic [CAR_IDX_W-1:0]  rd_idx_r;
  logic                  sel_cmp_r, bsy_cmp_r;

  // Running selection and busiest results
  logic [CAR_IDX_W-1:0]  best_idx_r;
  logic [FLOOR_W-1:0]    best_d_r;
  logic [COUNT_BITS-1:0] best_trav_r;
  logic [CAR_IDX_W-1:0]  busy_r;
  logic [COUNT_BITS-1:0] maxc_r;

  logic                  out_valid_r;

  logic                  call_ok;
  logic [FLOOR_W-1:0]    ride;
  logic [FLOOR_W-1:0]    rd_floor;
  logic [COUNT_BITS-1:0] rd_trav;
  logic [FLOOR_W-1:0]    d;
  logic                  take_sel;
  logic                  take_bsy;
  logic [FLOOR_W:0]      add_small;
  logic [COUNT_BITS:0]   sum;
  logic [COUNT_BITS-1:0] new_trav;
  logic [31:0]           chosen_id, busy_id;
  logic [63:0]           maxc_ext;

  // Call check and ride length on the input port
  assign call_ok = ({1'b0, in_pickup_floor} < nf_r) && ({1'b0, in_dest_floor} < nf_r) &&
                   (in_pickup_floor != in_dest_floor);
  assign ride    = (in_pickup_floor > in_dest_floor) ? in_pickup_floor - in_dest_floor
                                                     : in_dest_floor - in_pickup_floor;

  assign sts.call_ok  = call_ok;
  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.num_cars = nc_r;

  // Entries never written read as the ground floor with nothing travelled
  assign rd_floor = rd_vld_r ? rd_floor_r : '0;
  assign rd_trav  = rd_vld_r ? rd_trav_r  : '0;
  assign d        = (rd_floor > pick_r) ? rd_floor - pick_r : pick_r - rd_floor;

  // Nearest car, then fewer floors travelled, then lower id
  assign take_sel = (rd_idx_r == '0) || (d < best_d_r) ||
                    ((d == best_d_r) && (rd_trav < best_trav_r));
  assign take_bsy = rd_trav > maxc_r;

  // Saturating update of the chosen car's count
  assign add_small = {1'b0, best_d_r} + {1'b0, ride_r};
  assign sum       = {1'b0, best_trav_r} + (COUNT_BITS+1)'(add_small);
  assign new_trav  = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nf_r <= NUM_FLOORS_RST;
      nc_r <= NUM_CARS_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_NUM_FLOORS) begin
        nf_r <= cfg_wdata[NF_W-1:0];
      end else if (cfg_index == REG_NUM_CARS) begin
        nc_r <= cfg_wdata[NC_W-1:0];
      end
    end
  end

  // Call item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pick_r <= in_pickup_floor;
      dest_r <= in_dest_floor;
      ride_r <= ride;
      ok_r   <= call_ok;
    end
  end

  // Car store write and registered read
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      mem_floor[best_idx_r] <= dest_r;
      mem_trav[best_idx_r]  <= new_trav;
    end
    if (cmd.rd_en) begin
      rd_floor_r <= mem_floor[rd_addr];
      rd_trav_r  <= mem_trav[rd_addr];
      rd_vld_r   <= vld_r[rd_addr];
      rd_idx_r   <= rd_addr;
    end
  end

  // Valid bits and compare-stage flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      sel_cmp_r <= 1'b0;
      bsy_cmp_r <= 1'b0;
    end else begin
      if (cmd.upd) begin
        vld_r[best_idx_r] <= 1'b1;
      end
      sel_cmp_r <= cmd.rd_en && !cmd.rd_busy;
      bsy_cmp_r <= cmd.rd_en && cmd.rd_busy;
    end
  end

  // Selection and busiest accumulators
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      maxc_r <= '0;
      busy_r <= '0;
    end else if (bsy_cmp_r && take_bsy) begin
      maxc_r <= rd_trav;
      busy_r <= rd_idx_r;
    end
    if (sel_cmp_r && take_sel) begin
      best_idx_r  <= rd_idx_r;
      best_d_r    <= d;
      best_trav_r <= rd_trav;
    end
  end

  // Output register
  assign chosen_id = 32'(best_idx_r) + 32'd1;
  assign busy_id   = 32'(busy_r) + 32'd1;
  assign maxc_ext  = 64'(maxc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_accepted        <= ok_r;
      out_chosen_car      <= ok_r ? chosen_id[CAR_ID_W-1:0] : '0;
      out_pickup_distance <= ok_r ? best_d_r : '0;
      out_busiest_car     <= busy_id[CAR_ID_W-1:0];
      out_busiest_count   <= maxc_ext[OUT_CNT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;

endmodule

### design/ecd_checker.sv
// Port-level checker for the dispatcher, bound to the top level.
module ecd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_accepted,
  input logic [ecd_pkg::CAR_ID_W-1:0]   out_chosen_car,
  input logic [ecd_pkg::FLOOR_W-1:0]    out_pickup_distance,
  input logic [ecd_pkg::CAR_ID_W-1:0]   out_busiest_car,
  input logic [ecd_pkg::OUT_CNT_W-1:0]  out_busiest_count
);
  import ecd_pkg::*;

  // A stalled result item holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_chosen_car) &&
      $stable(out_busiest_count) && $stable(out_accepted))
    else $error("result item changed while stalled");

  // Only one call in flight
  a_one_call: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second call accepted back to back");

  // Rejected calls report no car and no distance
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_chosen_car == '0 && out_pickup_distance == '0)
    else $error("rejected call carries a car");

  // Dispatched calls name a real car
  a_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_chosen_car != '0)
    else $error("dispatched call without a car");

  // Idle fleet reports car 1 as busiest
  a_idle_fleet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_busiest_count == '0 |-> out_busiest_car == CAR_ID_W'(1))
    else $error("busiest car wrong for zero count");

endmodule

bind elevator_call_dispatch_unit ecd_checker u_ecd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_accepted        (out_accepted),
  .out_chosen_car      (out_chosen_car),
  .out_pickup_distance (out_pickup_distance),
  .out_busiest_car     (out_busiest_car),
  .out_busiest_count   (out_busiest_count)
);
